/* hw/rtl/date_add_signed_days_macros.svh */
// ----------------------------------------------------------------------------
// date_add_signed_days_macros.svh
// Assertion macros for the date adder. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef DATE_ADD_SIGNED_DAYS_MACROS_SVH
`define DATE_ADD_SIGNED_DAYS_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset
`define DASD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Check that a condition holds in the same cycle as its trigger
`define DASD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define DASD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DASD_ASSERT_ALWAYS(lbl, cond, msg)
`define DASD_ASSERT_IMPL(lbl, ante, cons, msg)
`define DASD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* hw/rtl/dasd_pkg.sv */
// ----------------------------------------------------------------------------
// dasd_pkg
// Shared widths, calendar constants, controller states and the month length
// function of the date adder.
// ----------------------------------------------------------------------------
package dasd_pkg;

	// Field widths
	localparam int YEAR_W = 14;
	localparam int MON_W  = 4;
	localparam int DAY_W  = 5;
	localparam int OFF_W  = 17;
	localparam int DD_W   = 18;
	localparam int QUO_W  = 8;

	// Calendar limits
	localparam int MAX_OFFSET = 65535;
	localparam logic [YEAR_W-1:0] YEAR_MIN = YEAR_W'(1);
	localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);
	localparam logic [MON_W-1:0]  MON_JAN  = MON_W'(1);
	localparam logic [MON_W-1:0]  MON_FEB  = MON_W'(2);
	localparam logic [MON_W-1:0]  MON_DEC  = MON_W'(12);
	localparam logic [DAY_W-1:0]  DAY_FIRST = DAY_W'(1);
	localparam logic [DAY_W-1:0]  DAY_LAST  = DAY_W'(31);
	localparam logic signed [DD_W-1:0] OFF_LIM = DD_W'(MAX_OFFSET);

	// Division by 100 as multiply and shift, exact for any 14-bit year
	localparam int DIV100_W     = 13;
	localparam int DIV100_SHIFT = 19;
	localparam logic [DIV100_W-1:0] DIV100_MUL = DIV100_W'(5243);
	localparam int PROD_W = YEAR_W + DIV100_W;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETTLE,
		ST_CHECK,
		ST_STEP,
		ST_FIN
	} dasd_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic check;
		logic step;
		logic publish;
	} dasd_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic date_ok;
		logic done;
	} dasd_status_t;

	// Length of a month, zero for a month code outside the calendar
	function automatic logic [DAY_W-1:0] days_in(input logic [MON_W-1:0] mon, input logic leap);
		logic [DAY_W-1:0] len;
		len = '0;
		case (mon) inside
			MON_FEB:                                  len = leap ? DAY_W'(29) : DAY_W'(28);
			MON_W'(4), MON_W'(6), MON_W'(9), MON_W'(11): len = DAY_W'(30);
			MON_W'(1), MON_W'(3), MON_W'(5), MON_W'(7),
			MON_W'(8), MON_W'(10), MON_DEC:           len = DAY_LAST;
			default:                                  len = '0;
		endcase
		return len;
	endfunction

endpackage

/* hw/rtl/dasd_ctrl.sv */
// ----------------------------------------------------------------------------
// dasd_ctrl
// Sequencer of the date adder: takes an input beat, walks the datapath one
// month per cycle and hands the result to the output register.
// ----------------------------------------------------------------------------
module dasd_ctrl import dasd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  logic         out_stall,
	input  dasd_status_t status,
	output dasd_cmd_t    cmd
);

	dasd_state_t state_q, state_d;
	logic        out_valid_q;

	// State and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SETTLE;
				end
			end
			ST_SETTLE: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (status.date_ok) begin
					cmd.check = 1'b1;
					state_d   = ST_STEP;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_STEP: begin
				if (status.done) begin
					state_d = ST_FIN;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* hw/rtl/dasd_dp.sv */
// ----------------------------------------------------------------------------
// dasd_dp
// Datapath of the date adder: working date registers, leap year logic, one
// month of carry or borrow per step, and the output register.
// ----------------------------------------------------------------------------
module dasd_dp import dasd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dasd_cmd_t               cmd,
	output dasd_status_t            status,
	input  logic [YEAR_W-1:0]       in_year,
	input  logic [MON_W-1:0]        in_month,
	input  logic [DAY_W-1:0]        in_day,
	input  logic signed [OFF_W-1:0] day_offset,
	output logic [YEAR_W-1:0]       out_year,
	output logic [MON_W-1:0]        out_month,
	output logic [DAY_W-1:0]        out_day,
	output logic                    input_invalid,
	output logic                    year_out_of_range
);

	logic [YEAR_W-1:0]      year_q;
	logic [MON_W-1:0]       month_q;
	logic signed [DD_W-1:0] dd_q;
	logic signed [DD_W-1:0] off_q;
	logic                   inv_q;
	logic                   oor_q;
	logic [QUO_W-1:0]       quo_q;

	logic [PROD_W-1:0]      prod;
	logic [YEAR_W-1:0]      hundred;
	logic                   leap;
	logic [DAY_W-1:0]       len_cur;
	logic [DAY_W-1:0]       len_prev;
	logic signed [DD_W-1:0] len_cur_x;
	logic signed [DD_W-1:0] len_prev_x;
	logic signed [DD_W-1:0] off_x;
	logic signed [DD_W-1:0] off_sat;
	logic                   neg;

	// Year divided by 100, registered; ST_SETTLE lets the quotient catch up with a newly loaded year
	assign prod = PROD_W'(year_q) * PROD_W'(DIV100_MUL);

	always_ff @(posedge clk) begin
		quo_q <= prod[DIV100_SHIFT +: QUO_W];
	end

	// Leap rule: divisible by 4, and not a century unless divisible by 400
	assign hundred = YEAR_W'({quo_q, 6'b0}) + YEAR_W'({quo_q, 5'b0}) + YEAR_W'({quo_q, 2'b0});
	assign leap    = (year_q[1:0] == 2'b00) && ((hundred != year_q) || (quo_q[1:0] == 2'b00));

	// Month lengths of the current and the previous month
	assign len_cur    = days_in(month_q, leap);
	assign len_prev   = days_in(month_q - MON_W'(1), leap);
	assign len_cur_x  = $signed({{(DD_W-DAY_W){1'b0}}, len_cur});
	assign len_prev_x = $signed({{(DD_W-DAY_W){1'b0}}, len_prev});
	assign neg        = off_q[DD_W-1];

	// Clamp the offset magnitude
	assign off_x = {day_offset[OFF_W-1], day_offset};
	always_comb begin
		off_sat = off_x;
		if (off_x > OFF_LIM) begin
			off_sat = OFF_LIM;
		end else if (off_x < -OFF_LIM) begin
			off_sat = -OFF_LIM;
		end
	end

	// Status to the controller
	assign status.date_ok = (year_q >= YEAR_MIN) && (year_q <= YEAR_MAX) &&
	                        (dd_q[DAY_W-1:0] != '0) && (dd_q[DAY_W-1:0] <= len_cur);
	assign status.done    = oor_q || (neg ? (dd_q > 0) : (dd_q <= len_cur_x));

	// Working date: load, apply offset, then carry or borrow a month per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= 1'b0;
			oor_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				inv_q <= 1'b1;
				oor_q <= 1'b0;
			end else if (cmd.check) begin
				inv_q <= 1'b0;
			end else if (cmd.step) begin
				if (!neg && month_q == MON_DEC && year_q == YEAR_MAX) begin
					oor_q <= 1'b1;
				end else if (neg && month_q == MON_JAN && year_q == YEAR_MIN) begin
					oor_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			year_q  <= in_year;
			month_q <= in_month;
			dd_q    <= $signed({{(DD_W-DAY_W){1'b0}}, in_day});
			off_q   <= off_sat;
		end else if (cmd.check) begin
			dd_q <= dd_q + off_q;
		end else if (cmd.step) begin
			if (!neg) begin
				// Carry forward past the end of the month
				if (month_q == MON_DEC) begin
					if (year_q == YEAR_MAX) begin
						dd_q <= $signed({{(DD_W-DAY_W){1'b0}}, DAY_LAST});
					end else begin
						month_q <= MON_JAN;
						year_q  <= year_q + YEAR_W'(1);
						dd_q    <= dd_q - len_cur_x;
					end
				end else begin
					month_q <= month_q + MON_W'(1);
					dd_q    <= dd_q - len_cur_x;
				end
			end else begin
				// Borrow back from the previous month
				if (month_q == MON_JAN) begin
					if (year_q == YEAR_MIN) begin
						dd_q <= $signed({{(DD_W-DAY_W){1'b0}}, DAY_FIRST});
					end else begin
						month_q <= MON_DEC;
						year_q  <= year_q - YEAR_W'(1);
						dd_q    <= dd_q + $signed({{(DD_W-DAY_W){1'b0}}, DAY_LAST});
					end
				end else begin
					month_q <= month_q - MON_W'(1);
					dd_q    <= dd_q + len_prev_x;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_year          <= year_q;
			out_month         <= month_q;
			out_day           <= dd_q[DAY_W-1:0];
			input_invalid     <= inv_q;
			year_out_of_range <= oor_q;
		end
	end

endmodule

/* hw/rtl/date_add_signed_days.sv */
// ----------------------------------------------------------------------------
// date_add_signed_days
// Adds a signed day offset to a Gregorian calendar date.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry a beat of in_year, in_month, in_day
// and day_offset. Output channel: out_valid/out_stall carry a beat of
// out_year, out_month, out_day, input_invalid and year_out_of_range.
// One input beat gives exactly one output beat.
// A beat is loaded in ST_IDLE and goes through ST_SETTLE, ST_CHECK, ST_STEP
// and ST_FIN, with one month boundary crossed per step; the single month
// stepper in the datapath sets the time taken, and one item is worked on
// at a time. An invalid start date skips ST_STEP and is returned unchanged
// with input_invalid set; a result past year 9999 or before year 1 saturates
// and sets year_out_of_range. A new beat is taken only in ST_IDLE, which
// the controller enters as the result is written to the output register.
// While a result waits under out_stall a new beat is still taken; a finished
// item then waits in the controller until the output register is free.
// Reset clears the controller and the output valid; no result is pending.
// ----------------------------------------------------------------------------
`include "date_add_signed_days_macros.svh"

module date_add_signed_days import dasd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [YEAR_W-1:0]       in_year,
	input  logic [MON_W-1:0]        in_month,
	input  logic [DAY_W-1:0]        in_day,
	input  logic signed [OFF_W-1:0] day_offset,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [YEAR_W-1:0]       out_year,
	output logic [MON_W-1:0]        out_month,
	output logic [DAY_W-1:0]        out_day,
	output logic                    input_invalid,
	output logic                    year_out_of_range
);

	dasd_cmd_t    cmd;
	dasd_status_t status;

	// Sequencer
	dasd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Date registers and month stepper
	dasd_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.in_year           (in_year),
		.in_month          (in_month),
		.in_day            (in_day),
		.day_offset        (day_offset),
		.out_year          (out_year),
		.out_month         (out_month),
		.out_day           (out_day),
		.input_invalid     (input_invalid),
		.year_out_of_range (year_out_of_range)
	);

	// Block is busy after taking a beat
	`DASD_ASSERT_NEXT(a_busy_after_beat, in_valid && !in_stall, in_stall, "no stall after input beat")

	// An invalid date never reports a saturated year
	`DASD_ASSERT_IMPL(a_flags_exclusive, out_valid, !(input_invalid && year_out_of_range), "both flags set")

	// A valid result is a proper calendar date
	`DASD_ASSERT_IMPL(a_result_date, out_valid && !input_invalid, (out_month >= MON_JAN) && (out_month <= MON_DEC) && (out_day != '0) && (out_year >= YEAR_MIN) && (out_year <= YEAR_MAX), "result date out of range")

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the date adder against a calendar walker of its own. A table of
// directed dates (range edges, leap rules, invalid dates, saturation) runs
// first, then about 245 random dates, mostly valid with small offsets, some
// spanning the full offset range, and some raw noise. The sender works in
// bursts and the receiver stalls on its own pattern, with one long hold-off
// that fills the block. Every output beat is compared field by field.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dasd_pkg::*;

	localparam int RANDOM_ITEMS    = 245;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int DRAIN_CYCLES    = 16;
	localparam int PRINT_LIMIT     = 50;

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [MON_W-1:0]  month;
		logic [DAY_W-1:0]  day;
		logic [OFF_W-1:0]  offset;
	} date_beat_t;

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [MON_W-1:0]  month;
		logic [DAY_W-1:0]  day;
		logic              invalid;
		logic              oor;
	} date_res_t;

	typedef struct packed {
		date_beat_t stim;
		logic       typed;
		date_res_t  res;
	} date_row_t;

	// Directed dates; rows with typed set carry their result, the rest use the walker
	localparam date_row_t DIRECTED [25] = '{
		'{'{2000, 2, 29, 0},           1'b1, '{2000, 2, 29, 1'b0, 1'b0}},
		'{'{1, 1, 1, 0},               1'b1, '{1, 1, 1, 1'b0, 1'b0}},
		'{'{9999, 12, 31, 1},          1'b1, '{9999, 12, 31, 1'b0, 1'b1}},
		'{'{1, 1, 1, -1},              1'b1, '{1, 1, 1, 1'b0, 1'b1}},
		'{'{0, 1, 1, 5},               1'b1, '{0, 1, 1, 1'b1, 1'b0}},
		'{'{16383, 15, 31, -65536},    1'b1, '{16383, 15, 31, 1'b1, 1'b0}},
		'{'{10000, 1, 1, 1},           1'b1, '{10000, 1, 1, 1'b1, 1'b0}},
		'{'{2023, 13, 1, 10},          1'b1, '{2023, 13, 1, 1'b1, 1'b0}},
		'{'{2023, 0, 10, -10},         1'b1, '{2023, 0, 10, 1'b1, 1'b0}},
		'{'{2023, 2, 29, 1},           1'b1, '{2023, 2, 29, 1'b1, 1'b0}},
		'{'{2023, 4, 0, 1},            1'b1, '{2023, 4, 0, 1'b1, 1'b0}},
		'{'{2023, 4, 31, -1},          1'b1, '{2023, 4, 31, 1'b1, 1'b0}},
		'{'{1900, 2, 29, 1},           1'b1, '{1900, 2, 29, 1'b1, 1'b0}},
		'{'{2024, 2, 28, 1},           1'b0, '{0, 0, 0, 1'b0, 1'b0}},
		'{'{2100, 2, 28, 1},           1'b0, '{0, 0, 0, 1'b0, 1'b0}},
		'{'{2023, 12, 31, 1},          1'b0, '{0, 0, 0, 1'b0, 1'b0}},
		'{'{2024, 1, 1, -1},           1'b0, '{0, 0, 0, 1'b0, 1'b0}},
		'{'{2000, 3, 1, -1},           1'b0, '{0, 0, 0, 1'b0, 1'b0}},
		'{'{5000, 6, 15, 65535},       1'b0, '{0, 0, 0, 1'b0, 1'b0}},
		'{'{5000, 6, 15, -65535},      1'b0, '{0, 0, 0, 1'b0, 1'b0}},
		'{'{5000, 6, 15, -65536},      1'b0, '{0, 0, 0, 1'b0, 1'b0}},
		'{'{9990, 1, 1, 65535},        1'b0, '{0, 0, 0, 1'b0, 1'b0}},
		'{'{10, 1, 1, -65535},         1'b0, '{0, 0, 0, 1'b0, 1'b0}},
		'{'{1, 1, 1, 65535},           1'b0, '{0, 0, 0, 1'b0, 1'b0}},
		'{'{9999, 12, 31, -65535},     1'b0, '{0, 0, 0, 1'b0, 1'b0}}
	};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [YEAR_W-1:0]       in_year = '0;
	logic [MON_W-1:0]        in_month = '0;
	logic [DAY_W-1:0]        in_day = '0;
	logic signed [OFF_W-1:0] day_offset = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [YEAR_W-1:0]       out_year;
	logic [MON_W-1:0]        out_month;
	logic [DAY_W-1:0]        out_day;
	logic                    input_invalid;
	logic                    year_out_of_range;

	date_res_t dates_due [$];
	int        mismatches = 0;
	int        idle_cycles = 0;
	bit        random_phase = 1'b0;

	date_add_signed_days i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.in_year           (in_year),
		.in_month          (in_month),
		.in_day            (in_day),
		.day_offset        (day_offset),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.out_year          (out_year),
		.out_month         (out_month),
		.out_day           (out_day),
		.input_invalid     (input_invalid),
		.year_out_of_range (year_out_of_range)
	);

	always #5 clk = ~clk;

	// Hold reset from the start, release once
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic bit leap_year(input int yr);
		return yr > 0 && ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0);
	endfunction

	function automatic int month_days(input int yr, input int mo);
		case (mo)
			2:                       return leap_year(yr) ? 29 : 28;
			4, 6, 9, 11:             return 30;
			1, 3, 5, 7, 8, 10, 12:   return 31;
			default:                 return 0;
		endcase
	endfunction

	// Walk the calendar a month at a time to find the resulting date
	function automatic date_res_t add_days(input date_beat_t b);
		date_res_t r;
		int        yr;
		int        mo;
		int        dy;
		int        off;
		bit        ok;
		yr = b.year;
		mo = b.month;
		dy = b.day;
		off = $signed(b.offset);
		r = '0;
		if (off > MAX_OFFSET) off = MAX_OFFSET;
		if (off < -MAX_OFFSET) off = -MAX_OFFSET;
		ok = yr >= int'(YEAR_MIN) && yr <= int'(YEAR_MAX) && mo >= int'(MON_JAN) &&
			mo <= int'(MON_DEC) && dy >= 1 && dy <= month_days(yr, mo);
		if (ok) begin
			dy += off;
			if (off >= 0) begin
				// carry whole months forward
				while (!r.oor && dy > month_days(yr, mo)) begin
					dy -= month_days(yr, mo);
					mo++;
					if (mo > int'(MON_DEC)) begin
						mo = MON_JAN;
						yr++;
						if (yr > int'(YEAR_MAX)) begin
							yr = YEAR_MAX;
							mo = MON_DEC;
							dy = DAY_LAST;
							r.oor = 1'b1;
						end
					end
				end
			end else begin
				// borrow whole months backward
				while (!r.oor && dy <= 0) begin
					mo--;
					if (mo < int'(MON_JAN)) begin
						mo = MON_DEC;
						yr--;
						if (yr < int'(YEAR_MIN)) begin
							yr = YEAR_MIN;
							mo = MON_JAN;
							dy = DAY_FIRST;
							r.oor = 1'b1;
						end
					end
					if (!r.oor) dy += month_days(yr, mo);
				end
			end
		end
		r.year = YEAR_W'(yr);
		r.month = MON_W'(mo);
		r.day = DAY_W'(dy);
		r.invalid = !ok;
		return r;
	endfunction

	// Mostly valid dates with small offsets, a few full-range, some raw noise
	function automatic date_beat_t random_beat();
		date_beat_t b;
		int         mag;
		if ($urandom_range(0, 9) < 2) begin
			b.year = $urandom_range(0, (1 << YEAR_W) - 1);
			b.month = $urandom_range(0, (1 << MON_W) - 1);
			b.day = $urandom_range(0, (1 << DAY_W) - 1);
			b.offset = $urandom_range(0, (1 << OFF_W) - 1);
			return b;
		end
		case ($urandom_range(0, 5))
			0:       b.year = $urandom_range(1, 6);
			1:       b.year = $urandom_range(9994, 9999);
			default: b.year = $urandom_range(1, 9999);
		endcase
		b.month = $urandom_range(1, 12);
		b.day = $urandom_range(1, month_days(b.year, b.month));
		case ($urandom_range(0, 9))
			0:       mag = $urandom_range(0, MAX_OFFSET);
			1, 2:    mag = $urandom_range(0, 4000);
			default: mag = $urandom_range(0, 400);
		endcase
		b.offset = OFF_W'($urandom_range(0, 1) ? -mag : mag);
		return b;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < PRINT_LIMIT)
			$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Offer one beat and hold it until taken, then queue its result
	task automatic deliver(input date_beat_t b, input bit typed, input date_res_t known);
		in_valid <= 1'b1;
		in_year <= b.year;
		in_month <= b.month;
		in_day <= b.day;
		day_offset <= b.offset;
		do @(posedge clk); while (in_stall);
		dates_due.push_back(typed ? known : add_days(b));
	endtask

	// Sender: directed table, a full drain, then random bursts
	initial begin : stimulus
		int sent;
		int burst;
		@(posedge arst_n);
		@(posedge clk);
		for (int i = 0; i < $size(DIRECTED); i++) begin
			deliver(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].res);
			if ($urandom_range(0, 3) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
		do @(posedge clk); while (dates_due.size() != 0);
		random_phase = 1'b1;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 16);
			repeat (burst) begin
				deliver(random_beat(), 1'b0, '0);
				sent++;
			end
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
		do @(posedge clk); while (dates_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("date_add_signed_days verification clean");
		else
			$display("date_add_signed_days verification failed");
		$finish;
	end

	// Receiver: free runs, random stalls, solid stalls, one long hold-off
	initial begin : receiver
		int mode;
		int span;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (random_phase && !held) begin
				held = 1'b1;
				mode = 2;
				span = HOLD_OFF_CYCLES;
			end else begin
				mode = $urandom_range(0, 2);
				span = mode == 2 ? $urandom_range(1, 12) : $urandom_range(4, 60);
			end
			repeat (span) begin
				out_stall <= mode == 2 || (mode == 1 && $urandom_range(0, 1) == 1);
				@(posedge clk);
			end
		end
	end

	// Compare each output beat with the oldest queued date
	always @(posedge clk) begin : check_results
		date_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (dates_due.size() == 0) begin
				report_mismatch("unexpected beat, out_year", out_year, 0);
			end else begin
				want = dates_due.pop_front();
				if (out_year !== want.year) report_mismatch("out_year", out_year, want.year);
				if (out_month !== want.month) report_mismatch("out_month", out_month, want.month);
				if (out_day !== want.day) report_mismatch("out_day", out_day, want.day);
				if (input_invalid !== want.invalid)
					report_mismatch("input_invalid", input_invalid, want.invalid);
				if (year_out_of_range !== want.oor)
					report_mismatch("year_out_of_range", year_out_of_range, want.oor);
			end
		end
	end

	// Count cycles with no beat on either side; give up past the limit
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d results outstanding", dates_due.size());
				$display("date_add_signed_days verification failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/dasd_pkg.sv
hw/rtl/dasd_ctrl.sv
hw/rtl/dasd_dp.sv
hw/rtl/date_add_signed_days.sv
test/testbench.sv
